### sv/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg
// Types and constants shared by the frame decoder files.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int CHANNELS    = 16;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int CHAN_W      = $clog2(CHANNELS);
  localparam int VAL_W       = 11;
  localparam int ACC_W       = VAL_W - 1 + 8;
  localparam int NB_W        = $clog2(ACC_W + 1);
  localparam int CNT_W       = 5;
  localparam int TMO_W       = 10;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [7:0]        HEADER      = 8'h0F;
  localparam logic [ADDR_W-1:0] HDR_ADDR    = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] DATA_ADDR   = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] FLAG_ADDR   = ADDR_W'(23);
  localparam logic [CNT_W-1:0]  FRAME_COUNT = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [TMO_W-1:0]  ELAPSED_MAX = '1;
  localparam logic [CHAN_W-1:0] LAST_CHAN   = CHAN_W'(CHANNELS - 1);
  localparam logic [NB_W-1:0]   VAL_BITS    = NB_W'(VAL_W);
  localparam logic [NB_W-1:0]   BYTE_BITS   = NB_W'(8);

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 10'd100;
  localparam logic [VAL_W-1:0] LOW_RST     = 11'd300;
  localparam logic [VAL_W-1:0] HIGH_RST    = 11'd1700;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic {
    KIND_CHANNEL = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_LOW     = 2'd1,
    REG_HIGH    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TMO_W-1:0] timeout_ms;
    logic [VAL_W-1:0] stick_low;
    logic [VAL_W-1:0] stick_high;
  } cfg_t;

endpackage

### sv/sbfd_if.sv
// ----------------------------------------------------------------------------
// sbfd_in_if / sbfd_out_if
// Valid/ready channels for input events and decoded results.
// ----------------------------------------------------------------------------
interface sbfd_in_if import sbfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface sbfd_out_if import sbfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAN_W-1:0] channel_index;
  logic [VAL_W-1:0]  channel_value;
  logic              aux_channel_17;
  logic              aux_channel_18;
  logic              lost_flag;
  logic              failsafe;
  logic              connected;
  logic              last;

  modport source (output valid, kind, channel_index, channel_value, aux_channel_17,
                  aux_channel_18, lost_flag, failsafe, connected, last, input ready);
  modport sink (input valid, kind, channel_index, channel_value, aux_channel_17,
                aux_channel_18, lost_flag, failsafe, connected, last, output ready);
endinterface

### sv/sbfd_ram.sv
// ----------------------------------------------------------------------------
// sbfd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sbfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sbfd_cfg.sv
// ----------------------------------------------------------------------------
// sbfd_cfg
// APB register file holding the timeout and the stick plausibility range.
// ----------------------------------------------------------------------------
module sbfd_cfg import sbfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms <= TIMEOUT_RST;
      cfg.stick_low  <= LOW_RST;
      cfg.stick_high <= HIGH_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TIMEOUT: cfg.timeout_ms <= pwdata[TMO_W-1:0];
        REG_LOW:     cfg.stick_low  <= pwdata[VAL_W-1:0];
        REG_HIGH:    cfg.stick_high <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT: prdata = PDATA_W'(cfg.timeout_ms);
      REG_LOW:     prdata = PDATA_W'(cfg.stick_low);
      REG_HIGH:    prdata = PDATA_W'(cfg.stick_high);
      default:     prdata = '0;
    endcase
  end

endmodule

### sv/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// Stores received bursts in a frame RAM and unpacks good frames into
// sixteen 11-bit channel reports; tracks link state and timeout.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   events    in         mode, rx_byte
//   results   out        kind, channel_index, channel_value, flags, connected, last
//   apb       in/out     timeout_ms, stick_low, stick_high
//
// Bytes, ticks and ignored events are handled in the idle state; no event is
// taken while a good frame is decoded. Each frame byte is read on the single
// RAM read port and merged, first over the stick channels for the range check,
// then over all sixteen channels while they are sent. Reset is synchronous and
// leaves the RAM untouched. A stalled result holds off events and channel reports.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core import sbfd_pkg::*; #(
  parameter int STICK_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  sbfd_in_if.sink            events,
  sbfd_out_if.source         results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [CHAN_W-1:0] LAST_STICK = CHAN_W'(STICK_CHANNELS - 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_HDR_RD  = 7'b0000010,
    S_HDR_CHK = 7'b0000100,
    S_FLG_RD  = 7'b0001000,
    S_FLG_LD  = 7'b0010000,
    S_FETCH   = 7'b0100000,
    S_MERGE   = 7'b1000000
  } state_t;

  cfg_t              cfg;
  state_t            state;
  logic [CNT_W-1:0]  byte_count;
  logic [TMO_W-1:0]  elapsed_ms;
  logic [TMO_W-1:0]  elapsed_next;
  logic              link_up;
  logic              check_pass;
  logic              bad;
  logic [3:0]        flags;
  logic [ACC_W-1:0]  acc;
  logic [NB_W-1:0]   nbits;
  logic [CHAN_W-1:0] chan;
  logic [ADDR_W-1:0] byte_ptr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic              ram_we;
  logic              accept;
  logic              slot_free;
  logic              have_val;
  logic [VAL_W-1:0]  val;
  logic              val_bad;
  logic              res_load;
  mode_t             mode;

  sbfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count[ADDR_W-1:0]),
    .wdata (events.rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign mode         = mode_t'(events.mode);
  assign slot_free    = !results.valid || results.ready;
  assign events.ready = (state == S_IDLE) && slot_free;
  assign accept       = events.valid && events.ready;
  assign ram_we       = accept && (mode == MODE_BYTE) && (byte_count < FRAME_COUNT);
  assign elapsed_next = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + TMO_W'(1) : elapsed_ms;
  assign have_val     = nbits >= VAL_BITS;
  assign val          = acc[VAL_W-1:0];
  assign val_bad      = (val < cfg.stick_low) || (val > cfg.stick_high);
  assign res_load     = (accept && (mode == MODE_TICK)) ||
                        ((state == S_FETCH) && have_val && !check_pass && slot_free);

  always_comb begin
    unique case (state)
      S_HDR_RD: raddr = HDR_ADDR;
      S_FLG_RD: raddr = FLAG_ADDR;
      default:  raddr = byte_ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (res_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_count    <= '0;
      elapsed_ms    <= '0;
      link_up       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              MODE_BYTE: begin
                if (byte_count != COUNT_MAX) begin
                  byte_count <= byte_count + CNT_W'(1);
                end
              end
              MODE_IDLE: begin
                byte_count <= '0;
                if (byte_count == FRAME_COUNT) begin
                  state <= S_HDR_RD;
                end
              end
              MODE_TICK: begin
                elapsed_ms            <= elapsed_next;
                results.kind          <= KIND_STATUS;
                results.channel_index <= '0;
                results.channel_value <= '0;
                results.aux_channel_17 <= 1'b0;
                results.aux_channel_18 <= 1'b0;
                results.lost_flag     <= 1'b0;
                results.failsafe      <= 1'b0;
                results.last          <= 1'b1;
                results.connected     <= link_up && !(elapsed_next > cfg.timeout_ms);
                if (elapsed_next > cfg.timeout_ms) begin
                  link_up <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_HDR_RD: state <= S_HDR_CHK;
        S_HDR_CHK: state <= (rdata == HEADER) ? S_FLG_RD : S_IDLE;
        S_FLG_RD: state <= S_FLG_LD;
        S_FLG_LD: begin
          flags      <= rdata[7:4];
          bad        <= rdata[5] || rdata[4];
          acc        <= '0;
          nbits      <= '0;
          chan       <= '0;
          byte_ptr   <= DATA_ADDR;
          check_pass <= 1'b1;
          state      <= S_FETCH;
        end
        S_FETCH: begin
          if (!have_val) begin
            state <= S_MERGE;
          end else if (check_pass) begin
            if (chan == LAST_STICK) begin
              link_up    <= !(bad || val_bad);
              elapsed_ms <= '0;
              acc        <= '0;
              nbits      <= '0;
              chan       <= '0;
              byte_ptr   <= DATA_ADDR;
              check_pass <= 1'b0;
            end else begin
              bad   <= bad || val_bad;
              acc   <= acc >> VAL_W;
              nbits <= nbits - VAL_BITS;
              chan  <= chan + CHAN_W'(1);
            end
          end else if (slot_free) begin
            results.kind           <= KIND_CHANNEL;
            results.channel_index  <= chan;
            results.channel_value  <= val;
            results.aux_channel_17 <= flags[3];
            results.aux_channel_18 <= flags[2];
            results.lost_flag      <= flags[1];
            results.failsafe       <= flags[0];
            results.connected      <= link_up;
            results.last           <= (chan == LAST_CHAN);
            acc   <= acc >> VAL_W;
            nbits <= nbits - VAL_BITS;
            chan  <= chan + CHAN_W'(1);
            if (chan == LAST_CHAN) begin
              state <= S_IDLE;
            end
          end
        end
        S_MERGE: begin
          acc      <= acc | (ACC_W'(rdata) << nbits);
          nbits    <= nbits + BYTE_BITS;
          byte_ptr <= byte_ptr + ADDR_W'(1);
          state    <= S_FETCH;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !events.ready)
    else $error("event accepted while a frame is being decoded");

  a_ptr_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (byte_ptr < FLAG_ADDR))
    else $error("channel unpacking read past the channel bytes");

  a_acc_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (nbits <= NB_W'(ACC_W)))
    else $error("bit accumulator overfilled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.kind == KIND_STATUS)) |-> results.last)
    else $error("status report not marked last");

endmodule

### test/sbfd_decode_checker.sv
// ----------------------------------------------------------------------------
// sbfd_decode_checker
// Watches the event, result and register channels of the frame decoder,
// predicts every channel and status report from the accepted requests and
// compares each accepted report with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sbfd_decode_checker import sbfd_pkg::*; #(
  parameter int STICK_CHANNELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  sbfd_in_if                 events,
  sbfd_out_if                results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  typedef struct {
    kind_t             kind;
    logic [CHAN_W-1:0] index;
    logic [VAL_W-1:0]  value;
    logic              aux17;
    logic              aux18;
    logic              lost;
    logic              failsafe;
    logic              connected;
    logic              last;
  } chan_report_t;

  chan_report_t expected_reports[$];

  logic [TMO_W-1:0] timeout_ms;
  logic [VAL_W-1:0] stick_low;
  logic [VAL_W-1:0] stick_high;
  logic [7:0]       frame_bytes[FRAME_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic [TMO_W-1:0] elapsed_ms;
  logic             link_up;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic decode_frame();
    logic [CHANNELS*VAL_W-1:0] payload;
    logic [VAL_W-1:0]          value;
    logic [7:0]                flags;
    logic                      bad;
    chan_report_t              rep;
    for (int k = 0; k < CHANNELS * VAL_W / 8; k++) begin
      payload[k*8 +: 8] = frame_bytes[DATA_ADDR + k];
    end
    flags = frame_bytes[FLAG_ADDR];
    bad = flags[5] | flags[4];
    for (int i = 0; i < STICK_CHANNELS && i < CHANNELS; i++) begin
      value = payload[i*VAL_W +: VAL_W];
      if (value < stick_low || value > stick_high) begin
        bad = 1'b1;
      end
    end
    link_up = ~bad;
    elapsed_ms = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      rep.kind      = KIND_CHANNEL;
      rep.index     = CHAN_W'(i);
      rep.value     = payload[i*VAL_W +: VAL_W];
      rep.aux17     = flags[7];
      rep.aux18     = flags[6];
      rep.lost      = flags[5];
      rep.failsafe  = flags[4];
      rep.connected = link_up;
      rep.last      = (CHAN_W'(i) == LAST_CHAN);
      expected_reports.push_back(rep);
    end
  endtask

  task automatic predict_event(input logic [1:0] mode, input logic [7:0] rx);
    chan_report_t rep;
    case (mode)
      MODE_BYTE: begin
        if (byte_count < FRAME_COUNT) begin
          frame_bytes[byte_count] = rx;
        end
        if (byte_count != COUNT_MAX) begin
          byte_count++;
        end
      end
      MODE_IDLE: begin
        if (byte_count == FRAME_COUNT && frame_bytes[HDR_ADDR] == HEADER) begin
          decode_frame();
        end
        byte_count = '0;
      end
      MODE_TICK: begin
        if (elapsed_ms != ELAPSED_MAX) begin
          elapsed_ms++;
        end
        if (elapsed_ms > timeout_ms) begin
          link_up = 1'b0;
        end
        rep.kind      = KIND_STATUS;
        rep.index     = '0;
        rep.value     = '0;
        rep.aux17     = 1'b0;
        rep.aux18     = 1'b0;
        rep.lost      = 1'b0;
        rep.failsafe  = 1'b0;
        rep.connected = link_up;
        rep.last      = 1'b1;
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic check_report();
    chan_report_t want;
    if (expected_reports.size() == 0) begin
      flag_mismatch("unpredicted report, index", 16'(results.channel_index), 16'd0);
      return;
    end
    want = expected_reports.pop_front();
    if (results.kind !== want.kind) begin
      flag_mismatch("kind", 16'(results.kind), 16'(want.kind));
    end
    if (results.channel_index !== want.index) begin
      flag_mismatch("channel_index", 16'(results.channel_index), 16'(want.index));
    end
    if (results.channel_value !== want.value) begin
      flag_mismatch("channel_value", 16'(results.channel_value), 16'(want.value));
    end
    if (results.aux_channel_17 !== want.aux17) begin
      flag_mismatch("aux_channel_17", 16'(results.aux_channel_17), 16'(want.aux17));
    end
    if (results.aux_channel_18 !== want.aux18) begin
      flag_mismatch("aux_channel_18", 16'(results.aux_channel_18), 16'(want.aux18));
    end
    if (results.lost_flag !== want.lost) begin
      flag_mismatch("lost_flag", 16'(results.lost_flag), 16'(want.lost));
    end
    if (results.failsafe !== want.failsafe) begin
      flag_mismatch("failsafe", 16'(results.failsafe), 16'(want.failsafe));
    end
    if (results.connected !== want.connected) begin
      flag_mismatch("connected", 16'(results.connected), 16'(want.connected));
    end
    if (results.last !== want.last) begin
      flag_mismatch("last", 16'(results.last), 16'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_ms = TIMEOUT_RST;
      stick_low  = LOW_RST;
      stick_high = HIGH_RST;
      byte_count = '0;
      elapsed_ms = '0;
      link_up    = 1'b0;
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_TIMEOUT: timeout_ms = pwdata[TMO_W-1:0];
          REG_LOW:     stick_low  = pwdata[VAL_W-1:0];
          REG_HIGH:    stick_high = pwdata[VAL_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        check_report();
      end
      if (events.valid && events.ready) begin
        predict_event(events.mode, events.rx_byte);
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

### test/sbus_frame_decoder_core_test.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core_test
// Drives byte, idle and tick requests into the frame decoder in bursts with
// random gaps, stalls the result side, and steps the registers through
// several settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sbfd_pkg::*;

  localparam int         STICK_N          = 4;
  localparam int         REG_STRIDE       = 4;
  localparam int         DRAIN_CYCLES     = 120;
  localparam int         HOLD_TICKS       = 12;
  localparam int         WATCHDOG_NS      = 5_000_000;
  localparam logic [1:0] MODE_UNUSED      = 2'd3;
  localparam logic [TMO_W-1:0] DIRECTED_TIMEOUT = 10'd2;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatch_count;
  int                 reports_pending;

  int               burst_left;
  int               events_sent;
  int               stall_style;
  int               stall_hold;
  logic [VAL_W-1:0] cur_low;
  logic [VAL_W-1:0] cur_high;

  sbfd_in_if  events_if();
  sbfd_out_if results_if();

  sbus_frame_decoder_core #(.STICK_CHANNELS(STICK_N)) dut (
    .clk     (clk),
    .rst     (rst),
    .events  (events_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sbfd_decode_checker #(.STICK_CHANNELS(STICK_N)) decode_check (
    .clk             (clk),
    .rst             (rst),
    .events          (events_if),
    .results         (results_if),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_hold  <= $urandom_range(16, 160);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_style)
      0:       results_if.ready <= 1'b1;
      1:       results_if.ready <= ($urandom_range(0, 3) != 0);
      2:       results_if.ready <= ($urandom_range(0, 2) == 0);
      default: results_if.ready <= (stall_hold[1:0] != 2'd0);
    endcase
  end

  task automatic push_event(input logic [1:0] mode, input logic [7:0] rx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        events_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    events_if.valid   <= 1'b1;
    events_if.mode    <= mode;
    events_if.rx_byte <= rx;
    @(posedge clk);
    while (!events_if.ready) @(posedge clk);
    burst_left--;
    if (mode != MODE_UNUSED) begin
      events_sent++;
    end
  endtask

  task automatic end_burst();
    events_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_STRIDE * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input logic [TMO_W-1:0] timeout, input logic [VAL_W-1:0] low,
                           input logic [VAL_W-1:0] high);
    write_reg(REG_TIMEOUT, PDATA_W'(timeout));
    write_reg(REG_LOW, PDATA_W'(low));
    write_reg(REG_HIGH, PDATA_W'(high));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_low  = low;
    cur_high = high;
  endtask

  task automatic settle();
    end_burst();
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHANNELS*VAL_W-1:0] random_channels(input bit sticks_ok);
    logic [CHANNELS*VAL_W-1:0] chans;
    int                        j;
    for (int i = 0; i < CHANNELS; i++) begin
      case ($urandom_range(0, 5))
        0:       chans[i*VAL_W +: VAL_W] = '0;
        1:       chans[i*VAL_W +: VAL_W] = '1;
        default: chans[i*VAL_W +: VAL_W] = VAL_W'($urandom_range(0, 2047));
      endcase
      if (sticks_ok && i < STICK_N && cur_low <= cur_high) begin
        case ($urandom_range(0, 3))
          0:       chans[i*VAL_W +: VAL_W] = cur_low;
          1:       chans[i*VAL_W +: VAL_W] = cur_high;
          default: chans[i*VAL_W +: VAL_W] =
                     VAL_W'($urandom_range(int'(cur_low), int'(cur_high)));
        endcase
      end
    end
    if (!sticks_ok && $urandom_range(0, 1) == 1) begin
      j = $urandom_range(0, STICK_N - 1);
      if (cur_low != '0) begin
        chans[j*VAL_W +: VAL_W] = cur_low - 1'b1;
      end else if (cur_high != '1) begin
        chans[j*VAL_W +: VAL_W] = cur_high + 1'b1;
      end
    end
    return chans;
  endfunction

  task automatic send_frame(input logic [CHANNELS*VAL_W-1:0] chans, input logic [7:0] flags,
                            input logic [7:0] tail, input int tick_slot);
    push_event(MODE_BYTE, HEADER);
    for (int k = 0; k < CHANNELS * VAL_W / 8; k++) begin
      if (k == tick_slot) begin
        push_event(MODE_TICK, 8'($urandom));
      end
      push_event(MODE_BYTE, chans[k*8 +: 8]);
    end
    push_event(MODE_BYTE, flags);
    push_event(MODE_BYTE, tail);
    push_event(MODE_IDLE, 8'($urandom));
  endtask

  task automatic random_sequence();
    int         pick;
    int         n;
    int         slot;
    logic [7:0] flags;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      slot  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 21) : -1;
      flags = 8'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        flags[5:4] = 2'b00;
      end
      send_frame(random_channels($urandom_range(0, 3) != 0), flags, 8'($urandom), slot);
    end else if (pick < 75) begin
      n = $urandom_range(1, 12);
      repeat (n) push_event(MODE_TICK, 8'($urandom));
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(0, 40);
          repeat (n) push_event(MODE_BYTE, 8'($urandom));
        end
        1: begin
          n = ($urandom_range(0, 1) == 1) ? FRAME_BYTES - 1 : FRAME_BYTES + 1;
          push_event(MODE_BYTE, HEADER);
          repeat (n - 1) push_event(MODE_BYTE, 8'($urandom));
        end
        default: begin
          push_event(MODE_BYTE, HEADER ^ 8'($urandom_range(1, 255)));
          repeat (FRAME_BYTES - 1) push_event(MODE_BYTE, 8'($urandom));
        end
      endcase
      push_event(MODE_IDLE, 8'($urandom));
    end else if (pick < 95) begin
      push_event(MODE_UNUSED, 8'($urandom));
    end else begin
      push_event(MODE_IDLE, 8'($urandom));
    end
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = events_sent;
    while (events_sent - start < budget) begin
      random_sequence();
    end
  endtask

  initial begin
    #(WATCHDOG_NS);
    $display("sbus_frame_decoder_core_test: done, errors");
    $finish;
  end

  initial begin
    logic [CHANNELS*VAL_W-1:0] chans;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    events_if.valid   = 1'b0;
    events_if.mode    = MODE_BYTE;
    events_if.rx_byte = '0;
    results_if.ready  = 1'b0;
    burst_left        = 0;
    events_sent       = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored mode, empty burst, a frame with sticks on the range
    // edges and the other channels at their extremes, then a timeout drop.
    configure(DIRECTED_TIMEOUT, LOW_RST, HIGH_RST);
    push_event(MODE_UNUSED, 8'hFF);
    push_event(MODE_IDLE, 8'h00);
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < STICK_N) begin
        chans[i*VAL_W +: VAL_W] = (i % 2 == 1) ? cur_high : cur_low;
      end else begin
        chans[i*VAL_W +: VAL_W] = (i % 2 == 1) ? '1 : '0;
      end
    end
    send_frame(chans, 8'hC0, 8'hFF, -1);
    repeat (3) push_event(MODE_TICK, 8'h00);
    settle();

    configure('0, '0, '1);
    random_phase(35);
    settle();

    configure(TMO_W'($urandom_range(1, 8)), VAL_W'($urandom_range(100, 600)),
              VAL_W'($urandom_range(1400, 1900)));
    random_phase(35);
    settle();

    // Inverted stick range: every decoded frame must come out disconnected.
    configure(TMO_W'(5), '1, '0);
    random_phase(25);
    settle();

    // With the largest timeout a run of ticks after a good frame keeps the link up.
    configure(ELAPSED_MAX, LOW_RST, HIGH_RST);
    send_frame(random_channels(1'b1), 8'h00, 8'($urandom), -1);
    repeat (HOLD_TICKS) push_event(MODE_TICK, 8'($urandom));
    settle();

    configure(TIMEOUT_RST, LOW_RST, HIGH_RST);
    random_phase(40);
    settle();

    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("sbus_frame_decoder_core_test: done, clean");
    end else begin
      $display("sbus_frame_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule

### sbus_frame_decoder_core.f
sv/sbfd_pkg.sv
sv/sbfd_if.sv
sv/sbfd_ram.sv
sv/sbfd_cfg.sv
sv/sbus_frame_decoder_core.sv
test/sbfd_decode_checker.sv
test/sbus_frame_decoder_core_test.sv
